// File: design/oets_pkg.sv
// ----------------------------------------------------------------------------
// Odd-even transposition sort package
// Shared constants and the control word that the top level hands to each cell.
// ----------------------------------------------------------------------------
`default_nettype none

package oets_pkg;

	localparam int MAX_ITEMS_DEF = 32;
	localparam int VALUE_W       = 64;

	typedef enum logic [1:0] {
		OP_HOLD      = 2'd0,
		OP_SHIFT_IN  = 2'd1,
		OP_SORT      = 2'd2,
		OP_SHIFT_OUT = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     parity;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// File: design/odd_even_transposition_sort_top.sv
// ----------------------------------------------------------------------------
// Odd-even transposition sort, top level
// Loads a set into a row of cells, sorts it in place, then streams it out.
// Loading accepts one beat per cycle; the sort runs n phases, one per cycle.
// Emission streams one beat per cycle while m_tready is high, and no new set
// is accepted until it ends. The first sorted beat follows the final phase.
// Reset clears the sequencer, the element count and the overflow flag.
// Cell values are not reset; only values of the current set are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module odd_even_transposition_sort_top #(
	parameter int MAX_ITEMS = oets_pkg::MAX_ITEMS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire  [oets_pkg::VALUE_W-1:0]      s_tdata,   // value[63:0]
	input  wire                               s_tlast,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [oets_pkg::VALUE_W-1:0]      m_tdata,   // sorted_value[63:0]
	output logic                              m_tlast,
	output logic                              m_tuser    // overflow[0]
);
	import oets_pkg::*;

	localparam int CW = $clog2(MAX_ITEMS + 1);

	typedef enum logic [2:0] {
		ST_LOAD = 3'b001,
		ST_SORT = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  phase_q;
	logic           ovf_q;
	logic           accept;
	logic           full;
	cell_ctrl_t     ctrl;

	logic signed [VALUE_W-1:0] cell_value [MAX_ITEMS];
	logic                      cell_swap  [MAX_ITEMS];

	assign s_tready = (state_q == ST_LOAD);
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == CW'(MAX_ITEMS));

	always_comb begin
		ctrl.parity = phase_q[0];
		case (state_q)
			ST_LOAD: ctrl.op = (accept && !full) ? OP_SHIFT_IN : OP_HOLD;
			ST_SORT: ctrl.op = OP_SORT;
			ST_EMIT: ctrl.op = m_tready ? OP_SHIFT_OUT : OP_HOLD;
			default: ctrl.op = OP_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			phase_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (!full) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							state_q <= ST_SORT;
							phase_q <= '0;
						end
					end
				end
				ST_SORT: begin
					if (phase_q == count_q - CW'(1)) begin
						state_q <= ST_EMIT;
					end else begin
						phase_q <= phase_q + CW'(1);
					end
				end
				ST_EMIT: begin
					if (m_tready) begin
						count_q <= count_q - CW'(1);
						if (count_q == CW'(1)) begin
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic signed [VALUE_W-1:0] left_value;
		logic signed [VALUE_W-1:0] right_value;
		logic                      swap_left;

		if (i == 0) begin : g_first
			assign left_value = $signed(s_tdata);
			assign swap_left  = 1'b0;
		end else begin : g_inner
			assign left_value = cell_value[i-1];
			assign swap_left  = cell_swap[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_last
			assign right_value = '0;
		end else begin : g_body
			assign right_value = cell_value[i+1];
		end

		oets_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.count       (count_q),
			.left_value  (left_value),
			.right_value (right_value),
			.swap_left   (swap_left),
			.value       (cell_value[i]),
			.swap_right  (cell_swap[i])
		);
	end

	assign m_tvalid = (state_q == ST_EMIT);
	assign m_tdata  = cell_value[0];
	assign m_tlast  = (count_q == CW'(1));
	assign m_tuser  = ovf_q;

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (count_q != '0))
		else $error("Output beat offered with an empty store.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ITEMS))
		else $error("Element count exceeds capacity.");

	a_phase_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SORT) |-> (phase_q < count_q))
		else $error("Sort phase beyond the element count.");

	a_sort_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SORT && phase_q == count_q - CW'(1)) |=> m_tvalid)
		else $error("Output not offered after the final phase.");

endmodule

`default_nettype wire

// File: design/oets_cell.sv
// ----------------------------------------------------------------------------
// Odd-even transposition sort cell
// Holds one value. Shifts in from the left, shifts out to the left, or
// compare-swaps with its right-hand neighbour in the phases of its parity.
// ----------------------------------------------------------------------------
`default_nettype none

module oets_cell #(
	parameter int IDX = 0,
	parameter int CW  = 6
) (
	input  wire                                     clk,
	input  oets_pkg::cell_ctrl_t                    ctrl,
	input  wire  [CW-1:0]                           count,
	input  wire  signed [oets_pkg::VALUE_W-1:0]     left_value,
	input  wire  signed [oets_pkg::VALUE_W-1:0]     right_value,
	input  wire                                     swap_left,
	output logic signed [oets_pkg::VALUE_W-1:0]     value,
	output logic                                    swap_right
);
	import oets_pkg::*;

	localparam logic [CW-1:0] NEXT_IDX = CW'(IDX + 1);
	localparam logic          IDX_PAR  = 1'(IDX % 2);

	logic signed [VALUE_W-1:0] value_q;
	logic                      pair_active;

	assign value       = value_q;
	assign pair_active = (ctrl.parity == IDX_PAR) && (NEXT_IDX < count);
	assign swap_right  = (ctrl.op == OP_SORT) && pair_active && (value_q > right_value);

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_SHIFT_IN: begin
				value_q <= left_value;
			end
			OP_SORT: begin
				if (swap_right) begin
					value_q <= right_value;
				end else if (swap_left) begin
					value_q <= left_value;
				end
			end
			OP_SHIFT_OUT: begin
				value_q <= right_value;
			end
			default: begin
				value_q <= value_q;
			end
		endcase
	end

endmodule

`default_nettype wire
